@@ rtl/deflate_fixed_huffman_encoder_core_defines.svh @@
// assertion macros shared by the deflate fixed huffman encoder rtl
// no dependencies; the using module must have clk and rst_n in scope
`ifndef DEFLATE_FIXED_HUFFMAN_ENCODER_CORE_DEFINES_SVH
`define DEFLATE_FIXED_HUFFMAN_ENCODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// clocked property, ignored while in reset
`define DFHE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dfhe assertion failed");
// clocked property, checked during reset too
`define DFHE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dfhe assertion failed");
`else
`define DFHE_ASSERT(lbl, prop)
`define DFHE_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ rtl/dfhe_pkg.sv @@
// types, constants and tables for the deflate fixed huffman encoder
// no dependencies
package dfhe_pkg;

  typedef enum logic [1:0] {
    MODE_BEGIN   = 2'd0,
    MODE_LITERAL = 2'd1,
    MODE_MATCH   = 2'd2,
    MODE_END     = 2'd3
  } mode_t;

  typedef struct packed {
    logic [30:0] bits;
    logic [4:0]  cnt;
    logic        is_begin;
    logic        is_end;
    logic        fin;
  } tok_code_t;

  localparam logic [1:0] BTYPE_FIXED      = 2'b01;
  localparam logic [7:0] LIT_SPLIT        = 8'd143;
  localparam logic [7:0] LIT_CODE_LO      = 8'h30;
  localparam logic [8:0] LIT_CODE_HI      = 9'h190;
  localparam logic [8:0] LIT_HI_FIRST     = 9'd144;
  localparam logic [4:0] LEN_IDX_SPLIT    = 5'd22;
  localparam logic [8:0] LEN_CODE_HI_BASE = 9'h0C0;
  localparam logic [8:0] LEN_MIN          = 9'd3;
  localparam logic [8:0] LEN_MAX          = 9'd258;
  localparam logic [15:0] DIST_MAX        = 16'd32768;

  localparam logic [8:0] LEN_BASE [29] = '{
    9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
    9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
    9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258};
  localparam logic [2:0] LEN_EXTRA [29] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd0};
  localparam logic [15:0] DIST_BASE [30] = '{
    16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17, 16'd25,
    16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257, 16'd385,
    16'd513, 16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073, 16'd4097,
    16'd6145, 16'd8193, 16'd12289, 16'd16385, 16'd24577};
  localparam logic [3:0] DIST_EXTRA [30] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
    4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
    4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13};

  // reverse the low n bits of v, msb-first huffman code into lsb-first order
  function automatic logic [8:0] rev_bits(input logic [8:0] v, input logic [3:0] n);
    logic [8:0] r;
    for (int k = 0; k < 9; k++) begin
      r[k] = v[8-k];
    end
    return r >> (4'd9 - n);
  endfunction

endpackage

@@ rtl/deflate_fixed_huffman_encoder_core.sv @@
// top level: input register, token encoder and output byte buffer
// first byte of a token is valid once the byte buffer takes it from the input register and loads the output register
// a token of n bytes holds the output register until its n bytes are popped (match up to 4)
// tokens of no bytes go at one per cycle, tokens of one byte at one per cycle while out_ready is high
// synchronous active-low reset clears pending bits, final flag and all valid flags
module deflate_fixed_huffman_encoder_core import dfhe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic        in_final_block,
  input  logic [7:0]  in_literal_byte,
  input  logic [8:0]  in_match_length,
  input  logic [15:0] in_match_distance,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run
);

  logic        tok_vld_r;
  mode_t       mode_r;
  logic        fin_r;
  logic [7:0]  lit_r;
  logic [8:0]  len_r;
  logic [15:0] dist_r;
  tok_code_t   code;
  logic        tok_take;

  assign in_ready = !tok_vld_r || tok_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else if (in_ready) begin
      tok_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= mode_t'(in_mode);
      fin_r  <= in_final_block;
      lit_r  <= in_literal_byte;
      len_r  <= in_match_length;
      dist_r <= in_match_distance;
    end
  end

  dfhe_token_enc u_enc (
    .mode           (mode_r),
    .final_block    (fin_r),
    .literal_byte   (lit_r),
    .match_length   (len_r),
    .match_distance (dist_r),
    .code           (code)
  );

  dfhe_byte_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_vld   (tok_vld_r),
    .tok       (code),
    .tok_take  (tok_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last_of_run)
  );

endmodule

@@ rtl/dfhe_token_enc.sv @@
// turns one registered token into its lsb-first bit string and bit count
// depends on dfhe_pkg
module dfhe_token_enc import dfhe_pkg::*; (
  input  mode_t       mode,
  input  logic        final_block,
  input  logic [7:0]  literal_byte,
  input  logic [8:0]  match_length,
  input  logic [15:0] match_distance,
  output tok_code_t   code
);

  logic [8:0]  len_c;
  logic [15:0] dist_c;
  logic [4:0]  lidx;
  logic [4:0]  didx;
  logic [8:0]  hcode;
  logic [4:0]  hcnt;
  logic [4:0]  lext;
  logic [4:0]  lecnt;
  logic [12:0] dext;
  logic [4:0]  decnt;
  logic [4:0]  dsym;
  logic [4:0]  sh_dsym;
  logic [4:0]  sh_dext;

  always_comb begin
    len_c = match_length;
    if (match_length < LEN_MIN) begin
      len_c = LEN_MIN;
    end else if (match_length > LEN_MAX) begin
      len_c = LEN_MAX;
    end
    dist_c = match_distance;
    if (match_distance == 16'd0) begin
      dist_c = 16'd1;
    end else if (match_distance > DIST_MAX) begin
      dist_c = DIST_MAX;
    end

    lidx = '0;
    for (int i = 1; i < 29; i++) begin
      if (len_c >= LEN_BASE[i]) lidx = 5'(i);
    end
    didx = '0;
    for (int i = 1; i < 30; i++) begin
      if (dist_c >= DIST_BASE[i]) didx = 5'(i);
    end

    lext  = 5'(len_c - LEN_BASE[lidx]);
    lecnt = {2'b00, LEN_EXTRA[lidx]};
    dext  = 13'(dist_c - DIST_BASE[didx]);
    decnt = {1'b0, DIST_EXTRA[didx]};
    dsym  = 5'(rev_bits({4'd0, didx}, 4'd5));

    if (lidx <= LEN_IDX_SPLIT) begin
      hcode = rev_bits(9'(lidx) + 9'd1, 4'd7);
      hcnt  = 5'd7;
    end else begin
      hcode = rev_bits(LEN_CODE_HI_BASE + 9'(lidx) - 9'(LEN_IDX_SPLIT) - 9'd1, 4'd8);
      hcnt  = 5'd8;
    end
    sh_dsym = hcnt + lecnt;
    sh_dext = sh_dsym + 5'd5;

    code.is_begin = (mode == MODE_BEGIN);
    code.is_end   = (mode == MODE_END);
    code.fin      = final_block;

    case (mode)
      MODE_BEGIN: begin
        code.bits = {28'd0, BTYPE_FIXED, final_block};
        code.cnt  = 5'd3;
      end
      MODE_LITERAL: begin
        if (literal_byte <= LIT_SPLIT) begin
          code.bits = {22'd0, rev_bits({1'b0, LIT_CODE_LO + literal_byte}, 4'd8)};
          code.cnt  = 5'd8;
        end else begin
          code.bits = {22'd0, rev_bits(LIT_CODE_HI + {1'b0, literal_byte} - LIT_HI_FIRST,
                                       4'd9)};
          code.cnt  = 5'd9;
        end
      end
      MODE_MATCH: begin
        code.bits = 31'(hcode) | (31'(lext) << hcnt) | (31'(dsym) << sh_dsym)
                  | (31'(dext) << sh_dext);
        code.cnt  = sh_dext + decnt;
      end
      MODE_END: begin
        code.bits = '0;
        code.cnt  = 5'd7;
      end
      default: begin
        code.bits = '0;
        code.cnt  = '0;
      end
    endcase
  end

endmodule

@@ rtl/dfhe_byte_buf.sv @@
// joins token bits to the pending bits and holds the completed bytes for output
// depends on dfhe_pkg and the assertion macro header
`include "deflate_fixed_huffman_encoder_core_defines.svh"

module dfhe_byte_buf import dfhe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      tok_vld,
  input  tok_code_t tok,
  output logic      tok_take,
  output logic      out_valid,
  input  logic      out_ready,
  output logic [7:0] out_byte,
  output logic      out_last
);

  logic [6:0]  pbits_r, pbits_nxt;
  logic [2:0]  pcnt_r, pcnt_nxt;
  logic        final_r, final_nxt;
  logic [31:0] data_r;
  logic [2:0]  bcnt_r;

  logic [37:0] acc;
  logic [37:0] rest;
  logic [5:0]  total;
  logic        pad;
  logic [2:0]  nbytes;
  logic        can_load;
  logic        load;
  logic        pop;

  always_comb begin
    acc      = 38'(pbits_r) | (38'(tok.bits) << pcnt_r);
    total    = 6'(pcnt_r) + 6'(tok.cnt);
    pad      = tok.is_end && final_r && (total[2:0] != 3'd0);
    nbytes   = 3'(total >> 3) + {2'b00, pad};
    rest     = acc >> {nbytes, 3'b000};
    can_load = (bcnt_r == 3'd0) || ((bcnt_r == 3'd1) && out_ready);
    tok_take = tok_vld && ((nbytes == 3'd0) || can_load);
    load     = tok_take && (nbytes != 3'd0);
    pop      = (bcnt_r != 3'd0) && out_ready;
    pbits_nxt = pad ? 7'd0 : rest[6:0];
    pcnt_nxt  = pad ? 3'd0 : total[2:0];
    final_nxt = tok.is_begin ? tok.fin : final_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pbits_r <= '0;
      pcnt_r  <= '0;
      final_r <= 1'b0;
      bcnt_r  <= '0;
    end else begin
      if (tok_take) begin
        pbits_r <= pbits_nxt;
        pcnt_r  <= pcnt_nxt;
        final_r <= final_nxt;
      end
      if (load) begin
        bcnt_r <= nbytes;
      end else if (pop) begin
        bcnt_r <= bcnt_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= acc[31:0];
    end else if (pop) begin
      data_r <= data_r >> 8;
    end
  end

  assign out_valid = (bcnt_r != 3'd0);
  assign out_byte  = data_r[7:0];
  assign out_last  = (bcnt_r == 3'd1);

  `DFHE_ASSERT(a_pend_clean, (pbits_r >> pcnt_r) == 7'd0)
  `DFHE_ASSERT(a_final_flush, (tok_take && tok.is_end && final_r) |=> (pcnt_r == 3'd0))
  `DFHE_ASSERT(a_pop_count, (pop && !load) |=> (bcnt_r == $past(bcnt_r) - 3'd1))
  `DFHE_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (bcnt_r == 3'd0 && pcnt_r == 3'd0))

endmodule
